// File: hw/rtl/assert_macros.svh
// Assertion macros used by the classifier unit RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent implies consequent, both written as full sequences.
`define ASSERT_IMPLIES(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(name, clk, rstn, prop, msg)

`endif

`endif

// File: hw/rtl/eflc_pkg.sv
// Types and constants for the Ethernet frame length classifier.
// No dependencies.
`timescale 1ns / 1ps

package eflc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] frame_length;
    } out_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FORWARD   = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] ETYPE_VLAN     = 16'h8100;
    localparam logic [15:0] ETYPE_PUP      = 16'h0200;
    localparam logic [15:0] ETYPE_SPRITE   = 16'h0500;
    localparam logic [15:0] ETYPE_REVARP   = 16'h8035;
    localparam logic [15:0] ETYPE_ATALK    = 16'h809B;
    localparam logic [15:0] ETYPE_AARP     = 16'h80F3;
    localparam logic [15:0] ETYPE_IPX      = 16'h8137;
    localparam logic [15:0] ETYPE_LOOPBACK = 16'h9000;

    localparam logic [7:0] PROTO_ZERO = 8'd0;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [4:0] OFF_ETYPE_HI  = 5'd12;
    localparam logic [4:0] OFF_ETYPE_LO  = 5'd13;
    localparam logic [4:0] OFF_IHL       = 5'd14;
    localparam logic [4:0] OFF_TOTLEN_HI = 5'd16;
    localparam logic [4:0] OFF_TOTLEN_LO = 5'd17;
    localparam logic [4:0] OFF_PAYLEN_HI = 5'd18;
    localparam logic [4:0] OFF_PAYLEN_LO = 5'd19;
    localparam logic [4:0] OFF_PROTO     = 5'd23;
    localparam logic [4:0] OFF_LIMIT     = 5'd24;

    localparam logic [16:0] ETH_HDR_BYTES  = 17'd14;
    localparam logic [16:0] ARP_LEN        = 17'd60;  // 28 + 18 pad + 14
    localparam logic [16:0] VLAN_LEN       = 17'd18;  // 14 + 4 tag
    localparam logic [16:0] IPV6_FIXED_LEN = 17'd54;  // 40 + 14
    localparam logic [3:0]  MIN_IHL_WORDS  = 4'd5;    // 20 bytes / 4

endpackage

// File: hw/rtl/ethernet_frame_length_classifier_unit.sv
// Ethernet frame length classifier: byte-wide frame in, one status/length per frame out.
// Depends on eflc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// A result enters the output register when the deciding byte is accepted while that
// register is free, and shows on m_valid in the next cycle.
// Throughput: one byte per cycle; header decode is a compare-and-capture per byte.
// A result register plus one skid entry let bytes flow while a result waits;
// s_ready drops only while both hold results.
// Reset: aresetn synchronous, active low; clears offset, captures and result valid flags.
`include "assert_macros.svh"

module ethernet_frame_length_classifier_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  eflc_pkg::in_t  s_payload,
    output logic         m_valid,
    input  logic         m_ready,
    output eflc_pkg::out_t m_payload
);
    import eflc_pkg::*;

    logic [4:0]  byte_offset_reg, byte_offset_next;
    logic [15:0] ether_kind_reg, ether_kind_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [15:0] ipv4_total_len_reg, ipv4_total_len_next;
    logic [7:0]  ipv6_len_hi_reg, ipv6_len_hi_next;
    logic        decided_reg, decided_next;

    logic        out_valid_reg, out_valid_next;
    out_t        out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    out_t        skid_data_reg, skid_data_next;

    logic        s_accept;
    logic        out_take;
    logic [7:0]  b;
    logic [15:0] kind_now;
    logic        legacy;
    logic        decide_now;
    logic        res_valid;
    out_t        res;

    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign out_take  = out_valid_reg && m_ready;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;
    assign b         = s_payload.data_byte;

    // EtherType as seen at the low byte, including the byte arriving now
    assign kind_now = {ether_kind_reg[15:8], b};

    assign legacy = (kind_now == ETYPE_PUP)    || (kind_now == ETYPE_SPRITE) ||
                    (kind_now == ETYPE_REVARP) || (kind_now == ETYPE_ATALK)  ||
                    (kind_now == ETYPE_AARP)   || (kind_now == ETYPE_IPX)    ||
                    (kind_now == ETYPE_LOOPBACK);

    // Decode the current byte against the captured header fields
    always_comb begin
        decide_now = 1'b0;
        res.status = ST_INVALID;
        res.frame_length = '0;
        priority if (byte_offset_reg == OFF_ETYPE_LO && kind_now != ETYPE_IPV4 &&
                     kind_now != ETYPE_IPV6) begin
            decide_now = 1'b1;
            priority if (kind_now == ETYPE_ARP) begin
                res.status = ST_OK;
                res.frame_length = ARP_LEN;
            end else if (kind_now == ETYPE_VLAN) begin
                res.status = ST_OK;
                res.frame_length = VLAN_LEN;
            end else if (legacy) begin
                res.status = ST_FORWARD;
            end else begin
                res.status = ST_INVALID;
            end
        end else if (byte_offset_reg == OFF_PAYLEN_LO && ether_kind_reg == ETYPE_IPV6) begin
            decide_now = 1'b1;
            res.status = ST_OK;
            res.frame_length = {1'b0, ipv6_len_hi_reg, b} + IPV6_FIXED_LEN;
        end else if (byte_offset_reg == OFF_PROTO && ether_kind_reg == ETYPE_IPV4) begin
            decide_now = 1'b1;
            if (b == PROTO_ZERO || b == PROTO_TCP || b == PROTO_UDP) begin
                if (header_words_reg < MIN_IHL_WORDS) begin
                    res.status = ST_INVALID;
                end else begin
                    res.status = ST_OK;
                    res.frame_length = {1'b0, ipv4_total_len_reg} + ETH_HDR_BYTES;
                end
            end else begin
                res.status = ST_FORWARD;
            end
        end else begin
            decide_now = 1'b0;
            if (s_payload.frame_end) begin
                res.status = ST_TRUNCATED;
            end
        end
    end

    assign res_valid = !decided_reg && (decide_now || s_payload.frame_end);

    // Frame parsing state
    always_comb begin
        byte_offset_next    = byte_offset_reg;
        ether_kind_next     = ether_kind_reg;
        header_words_next   = header_words_reg;
        ipv4_total_len_next = ipv4_total_len_reg;
        ipv6_len_hi_next    = ipv6_len_hi_reg;
        decided_next        = decided_reg;
        if (s_accept) begin
            if (!decided_reg) begin
                unique case (byte_offset_reg)
                    OFF_ETYPE_HI:  ether_kind_next = {b, 8'h00};
                    OFF_ETYPE_LO:  ether_kind_next = kind_now;
                    OFF_IHL:       header_words_next = b[3:0];
                    OFF_TOTLEN_HI: ipv4_total_len_next = {b, 8'h00};
                    OFF_TOTLEN_LO: ipv4_total_len_next = {ipv4_total_len_reg[15:8], b};
                    OFF_PAYLEN_HI: ipv6_len_hi_next = b;
                    default: ;
                endcase
                if (decide_now) begin
                    decided_next = 1'b1;
                end
            end
            if (s_payload.frame_end) begin
                // clear everything for the next frame
                byte_offset_next    = '0;
                ether_kind_next     = '0;
                header_words_next   = '0;
                ipv4_total_len_next = '0;
                ipv6_len_hi_next    = '0;
                decided_next        = 1'b0;
            end else if (byte_offset_reg < OFF_LIMIT) begin
                byte_offset_next = byte_offset_reg + 5'd1;
            end
        end
    end

    // Result register with one skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (s_accept && res_valid) begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (s_accept && res_valid) begin
            // output stalled: park the transaction
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg    <= '0;
            ether_kind_reg     <= '0;
            header_words_reg   <= '0;
            ipv4_total_len_reg <= '0;
            ipv6_len_hi_reg    <= '0;
            decided_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            byte_offset_reg    <= byte_offset_next;
            ether_kind_reg     <= ether_kind_next;
            header_words_reg   <= header_words_next;
            ipv4_total_len_reg <= ipv4_total_len_next;
            ipv6_len_hi_reg    <= ipv6_len_hi_next;
            decided_reg        <= decided_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ASSERT_ALWAYS(a_skid_behind_out, aclk, aresetn,
        !skid_valid_reg || out_valid_reg, "skid holds a result while output register is empty")
    `ASSERT_ALWAYS(a_offset_saturates, aclk, aresetn,
        byte_offset_reg <= OFF_LIMIT, "byte offset past saturation limit")
    `ASSERT_ALWAYS(a_decided_after_type, aclk, aresetn,
        !decided_reg || byte_offset_reg > OFF_ETYPE_LO, "decision flagged before EtherType")
    `ASSERT_ALWAYS(a_len_zero_unless_ok, aclk, aresetn,
        !out_valid_reg || out_data_reg.status == ST_OK || out_data_reg.frame_length == '0,
        "nonzero length on non-OK status")
    `ASSERT_IMPLIES(a_frame_end_clears, aclk, aresetn,
        (s_accept && s_payload.frame_end) |=> (byte_offset_reg == '0 && !decided_reg),
        "frame end did not clear parser state")

endmodule
